// ===== hdl/i2cmbw_pkg.sv =====
// Package for the write-only I2C master byte writer.
// Holds the item structs, command and phase codes, and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package i2cmbw_pkg;

  // Command codes carried in the func field
  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  // Sequencer phase codes
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ST_A  = 4'd1;
  localparam logic [3:0] PH_ST_B  = 4'd2;
  localparam logic [3:0] PH_ST_C  = 4'd3;
  localparam logic [3:0] PH_ST_D  = 4'd4;
  localparam logic [3:0] PH_BIT_A = 4'd5;
  localparam logic [3:0] PH_BIT_B = 4'd6;
  localparam logic [3:0] PH_BIT_C = 4'd7;
  localparam logic [3:0] PH_BIT_D = 4'd8;
  localparam logic [3:0] PH_ACK_A = 4'd9;
  localparam logic [3:0] PH_ACK_B = 4'd10;
  localparam logic [3:0] PH_ACK_C = 4'd11;
  localparam logic [3:0] PH_ACK_D = 4'd12;
  localparam logic [3:0] PH_SP_A  = 4'd13;
  localparam logic [3:0] PH_SP_B  = 4'd14;
  localparam logic [3:0] PH_SP_C  = 4'd15;

  localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;
  localparam logic [15:0] PHASE_TICKS_RST  = 16'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] address;
    logic       rw;
    logic [7:0] data_byte;
    logic       lsb_first;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_low;
    logic busy_res;
    logic byte_done;
    logic nack;
    logic stop_done;
    logic rejected;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] count;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic        lsb;
    logic        ack;
    logic        scl;
    logic        sda;
  } seq_state_t;

endpackage

// ===== hdl/i2cmbw_seq.sv =====
// Bus sequencer: state registers plus the one-tick next-state and result logic.
// Depends on i2cmbw_pkg.
`timescale 1ns / 1ps

module i2cmbw_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  i2cmbw_pkg::in_item_t  item_i,
  input  logic [15:0]           phase_ticks_i,
  output i2cmbw_pkg::out_item_t result_o
);

  i2cmbw_pkg::seq_state_t state_q, state_d;

  // Enter a phase: clear the tick count and apply that phase's pin change.
  function automatic i2cmbw_pkg::seq_state_t enter_phase(
    input i2cmbw_pkg::seq_state_t s_in,
    input logic [3:0]             ph
  );
    i2cmbw_pkg::seq_state_t s;
    s       = s_in;
    s.phase = ph;
    s.count = '0;
    case (ph)
      i2cmbw_pkg::PH_ST_A:  s.sda = 1'b1;
      i2cmbw_pkg::PH_ST_B:  s.scl = 1'b1;
      i2cmbw_pkg::PH_ST_C:  s.sda = 1'b0;
      i2cmbw_pkg::PH_ST_D:  s.scl = 1'b0;
      i2cmbw_pkg::PH_BIT_A: begin
        if (s.lsb) begin
          s.sda   = s.shift[0];
          s.shift = {1'b0, s.shift[7:1]};
        end else begin
          s.sda   = s.shift[7];
          s.shift = {s.shift[6:0], 1'b0};
        end
      end
      i2cmbw_pkg::PH_BIT_B: s.scl = 1'b1;
      i2cmbw_pkg::PH_BIT_D: s.scl = 1'b0;
      i2cmbw_pkg::PH_ACK_A: s.sda = 1'b1;
      i2cmbw_pkg::PH_ACK_B: s.scl = 1'b1;
      i2cmbw_pkg::PH_ACK_D: s.scl = 1'b0;
      i2cmbw_pkg::PH_SP_A:  s.sda = 1'b0;
      i2cmbw_pkg::PH_SP_B:  s.scl = 1'b1;
      i2cmbw_pkg::PH_SP_C:  s.sda = 1'b1;
      default: ;
    endcase
    return s;
  endfunction

  always_comb begin
    i2cmbw_pkg::seq_state_t s;
    logic [15:0] limit;
    logic [15:0] cnt;
    logic [3:0]  nbit;
    logic        rej, busy, bdone, nk, sdone, scl_now, sda_now;

    s     = state_q;
    limit = (phase_ticks_i == '0) ? 16'd1 : phase_ticks_i;
    rej   = 1'b0;
    bdone = 1'b0;
    nk    = 1'b0;
    sdone = 1'b0;
    cnt   = '0;
    nbit  = '0;

    // Command decode, only while idle
    if (s.phase != i2cmbw_pkg::PH_IDLE) begin
      rej = (item_i.func != i2cmbw_pkg::FUNC_NONE);
    end else begin
      case (item_i.func)
        i2cmbw_pkg::FUNC_START: begin
          s.shift   = {item_i.address, item_i.rw};
          s.lsb     = 1'b0;
          s.bit_cnt = '0;
          s         = enter_phase(s, i2cmbw_pkg::PH_ST_A);
        end
        i2cmbw_pkg::FUNC_WRITE: begin
          s.shift   = item_i.data_byte;
          s.lsb     = item_i.lsb_first;
          s.bit_cnt = '0;
          s         = enter_phase(s, i2cmbw_pkg::PH_BIT_A);
        end
        i2cmbw_pkg::FUNC_STOP: s = enter_phase(s, i2cmbw_pkg::PH_SP_A);
        default: ;
      endcase
    end

    busy    = (s.phase != i2cmbw_pkg::PH_IDLE);
    scl_now = s.scl;
    sda_now = s.sda;

    // Phase timing and advance
    if (busy) begin
      cnt     = s.count + 16'd1;
      s.count = cnt;
      if (s.phase == i2cmbw_pkg::PH_ACK_B && cnt == 16'd1) begin
        s.ack = ~item_i.sda_in;
      end
      if (cnt >= limit) begin
        case (s.phase)
          i2cmbw_pkg::PH_ST_D: s = enter_phase(s, i2cmbw_pkg::PH_BIT_A);
          i2cmbw_pkg::PH_BIT_D: begin
            nbit      = s.bit_cnt + 4'd1;
            s.bit_cnt = nbit;
            s = enter_phase(s, (nbit >= i2cmbw_pkg::BITS_PER_BYTE) ?
                               i2cmbw_pkg::PH_ACK_A : i2cmbw_pkg::PH_BIT_A);
          end
          i2cmbw_pkg::PH_ACK_D: begin
            bdone = 1'b1;
            nk    = ~s.ack;
            s.sda = 1'b1;
            s     = enter_phase(s, i2cmbw_pkg::PH_IDLE);
          end
          i2cmbw_pkg::PH_SP_C: begin
            sdone = 1'b1;
            s     = enter_phase(s, i2cmbw_pkg::PH_IDLE);
          end
          default: s = enter_phase(s, s.phase + 4'd1);
        endcase
      end
    end

    state_d            = s;
    result_o.scl_level = scl_now;
    result_o.sda_low   = ~sda_now;
    result_o.busy_res  = busy;
    result_o.byte_done = bdone;
    result_o.nack      = nk;
    result_o.stop_done = sdone;
    result_o.rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase   <= i2cmbw_pkg::PH_IDLE;
      state_q.count   <= '0;
      state_q.bit_cnt <= '0;
      state_q.shift   <= '0;
      state_q.lsb     <= 1'b0;
      state_q.ack     <= 1'b0;
      state_q.scl     <= 1'b1;
      state_q.sda     <= 1'b1;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/i2c_master_byte_writer_core.sv =====
// Top level of the write-only I2C master byte writer.
// Depends on i2cmbw_pkg and i2cmbw_seq.
`timescale 1ns / 1ps

// Usage:
// - Each input item is one tick of the bus timebase. It may carry a command
//   (start with address, write byte, stop) and always carries the sampled SDA.
//   Commands are taken only while no sequence runs; otherwise rejected pulses.
// - Every accepted item yields exactly one result item: driven SCL level,
//   SDA pull-down, busy, byte_done/nack, stop_done and rejected for that tick.
// - Input channel: in_valid_i / in_stall_o. Output: out_valid_o / out_stall_i.
//   Transfer happens when valid is high and stall is low.
// - Path: an item lands in the input register at the accepting edge; the
//   sequencer processes it and the result register loads its result at the
//   first edge at which the result register is free.
// - Throughput: one item per cycle unless the receiver stalls; the sequencer
//   update is a single pass of logic between the input and result registers.
// - On a receiver stall the result register holds; an empty input register
//   still takes one more item, then in_stall_o rises until the result drains.
// - phase_ticks is written by phase_ticks_we_i / phase_ticks_i; the user must
//   write it only while idle (not enforced by the block); 0 behaves as 1.
// - Reset: phase_ticks = 4, sequencer idle with SCL and SDA released high,
//   both pipeline registers empty.
module i2c_master_byte_writer_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  phase_ticks_we_i,
  input  logic [15:0]           phase_ticks_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cmbw_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cmbw_pkg::out_item_t out_item_o
);

  logic                  in_valid_q;
  i2cmbw_pkg::in_item_t  in_q;
  logic                  out_valid_q;
  i2cmbw_pkg::out_item_t out_q;
  logic [15:0]           phase_ticks_q;
  i2cmbw_pkg::out_item_t result;
  logic                  out_ready;
  logic                  fire;

  // Result register is free when empty or being drained this cycle
  assign out_ready  = ~out_valid_q | ~out_stall_i;
  // One tick processed when a buffered item meets a free result slot
  assign fire       = in_valid_q & out_ready;
  assign in_stall_o = in_valid_q & ~fire;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cmbw_pkg::PHASE_TICKS_RST;
    end else if (phase_ticks_we_i) begin
      phase_ticks_q <= phase_ticks_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  i2cmbw_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (in_q),
    .phase_ticks_i (phase_ticks_q),
    .result_o      (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for i2c_master_byte_writer_core.
// Drives bus ticks and checks every tick result against an in-bench sequencer
// model; depends on i2cmbw_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import i2cmbw_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 50_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 400;
  localparam int NOISE_PCT    = 3;          // chance of a stray command per fill tick
  localparam int MAX_REPORTS  = 100;
  localparam int FAST_ROW     = 2;          // script rows from here run at one tick per phase
  localparam int PEEK_TICKS   = 4;
  localparam int IN_W         = $bits(in_item_t);

  // Tick results that can be read straight off the waveform description
  localparam out_item_t BUS_IDLE      = 7'b1000000;  // both lines released, idle
  localparam out_item_t SEQ_ENTRY     = 7'b1010000;  // first start tick, SDA still high
  localparam out_item_t STOP_ENTRY    = 7'b1110000;  // first stop tick, SDA pulled low
  localparam out_item_t REJECTED_TICK = 7'b1010001;  // command while both lines still high

  typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_GAPS, PACE_BOTH_GAPS} pace_t;

  typedef struct packed {
    in_item_t  item;
    logic      run_out;  // follow with plain ticks until the bus is free
    logic      known;    // want holds the exact tick result
    out_item_t want;
  } script_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        phase_ticks_we_i = 1'b0;
  logic [15:0] phase_ticks_i    = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  out_item_t   out_item_o;

  // Bus sequencer model state
  logic [15:0] tick_len = PHASE_TICKS_RST;
  logic [3:0]  bus_ph   = PH_IDLE;
  logic [15:0] ph_cnt   = '0;
  logic [3:0]  bit_idx  = '0;
  logic [7:0]  sh_byte  = '0;
  logic        lsb_mode = 1'b0;
  logic        acked    = 1'b0;
  logic        scl_q    = 1'b1;
  logic        sda_q    = 1'b1;

  out_item_t   tick_q [$];  // predicted tick results, oldest first
  out_item_t   want_r;
  script_row_t script [$];
  logic [1:0]  cmd_set [3] = '{FUNC_START, FUNC_WRITE, FUNC_STOP};
  string       field_name [7] = '{"rejected", "stop_done", "nack", "byte_done",
                                  "busy_res", "sda_low", "scl_level"};

  int   mismatches   = 0;
  int   results_seen = 0;
  int   items_sent   = 0;
  int   cmds_sent    = 0;
  int   rejects_seen = 0;
  int   bytes_seen   = 0;
  int   nacks_seen   = 0;
  int   stops_seen   = 0;
  int   cycle_cnt    = 0;
  int   hold_left    = 0;
  int   gap_pct      = 0;
  int   stall_pct    = 0;
  logic last_nack    = 1'b0;

  i2c_master_byte_writer_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .phase_ticks_we_i(phase_ticks_we_i),
    .phase_ticks_i   (phase_ticks_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_o      (out_item_o)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Pin change made on entry to a phase; it shows on every tick of that phase.
  function automatic void enter_phase(logic [3:0] ph);
    bus_ph = ph;
    ph_cnt = '0;
    case (ph)
      PH_ST_A, PH_ACK_A, PH_SP_C:           sda_q = 1'b1;
      PH_ST_B, PH_BIT_B, PH_ACK_B, PH_SP_B: scl_q = 1'b1;
      PH_ST_C, PH_SP_A:                     sda_q = 1'b0;
      PH_ST_D, PH_BIT_D, PH_ACK_D:          scl_q = 1'b0;
      PH_BIT_A: begin
        if (lsb_mode) begin
          sda_q   = sh_byte[0];
          sh_byte = sh_byte >> 1;
        end else begin
          sda_q   = sh_byte[7];
          sh_byte = sh_byte << 1;
        end
      end
      default: ;
    endcase
  endfunction

  // One bus tick: take a command if idle, report pins, then advance the phase.
  function automatic out_item_t bus_tick(in_item_t it);
    out_item_t   r;
    logic [15:0] lim;
    r   = '0;
    lim = (tick_len == '0) ? 16'd1 : tick_len;
    if (bus_ph != PH_IDLE) begin
      r.rejected = (it.func != FUNC_NONE);
    end else begin
      case (it.func)
        FUNC_START: begin
          sh_byte  = {it.address, it.rw};
          lsb_mode = 1'b0;  // address always goes out MSB first
          bit_idx  = '0;
          enter_phase(PH_ST_A);
        end
        FUNC_WRITE: begin
          sh_byte  = it.data_byte;
          lsb_mode = it.lsb_first;
          bit_idx  = '0;
          enter_phase(PH_BIT_A);
        end
        FUNC_STOP: enter_phase(PH_SP_A);
        default: ;
      endcase
    end
    r.busy_res  = (bus_ph != PH_IDLE);
    r.scl_level = scl_q;
    r.sda_low   = ~sda_q;
    if (r.busy_res) begin
      ph_cnt = ph_cnt + 16'd1;
      // ack is taken on the first tick with SCL high only
      if (bus_ph == PH_ACK_B && ph_cnt == 16'd1) acked = ~it.sda_in;
      if (ph_cnt >= lim) begin
        case (bus_ph)
          PH_ST_D: enter_phase(PH_BIT_A);
          PH_BIT_D: begin
            bit_idx = bit_idx + 4'd1;
            enter_phase((bit_idx >= BITS_PER_BYTE) ? PH_ACK_A : PH_BIT_A);
          end
          PH_ACK_D: begin
            r.byte_done = 1'b1;
            r.nack      = ~acked;
            sda_q       = 1'b1;
            enter_phase(PH_IDLE);
          end
          PH_SP_C: begin
            r.stop_done = 1'b1;
            enter_phase(PH_IDLE);
          end
          default: enter_phase(bus_ph + 4'd1);
        endcase
      end
    end
    return r;
  endfunction

  function automatic script_row_t step_row(logic [1:0] f, logic [6:0] a, logic r,
                                           logic [7:0] d, logic l, logic s,
                                           logic run, logic known, out_item_t want);
    return {f, a, r, d, l, s, run, known, want};
  endfunction

  function automatic in_item_t rand_item(logic [1:0] f);
    in_item_t it;
    it      = in_item_t'(IN_W'($urandom));
    it.func = f;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL:      begin gap_pct = 0;  stall_pct = 0;  end
      PACE_SEND_GAPS: begin gap_pct = 79; stall_pct = 0;  end
      PACE_RECV_GAPS: begin gap_pct = 0;  stall_pct = 79; end
      default:        begin gap_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // Offer one item, hold it until taken, then predict its tick result.
  task automatic send_item(input in_item_t it);
    out_item_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    r = bus_tick(it);
    tick_q.push_back(r);
    items_sent++;
    if (it.func != FUNC_NONE) cmds_sent++;
    rejects_seen += r.rejected;
    stops_seen   += r.stop_done;
    if (r.byte_done) begin
      bytes_seen++;
      nacks_seen += r.nack;
      last_nack   = r.nack;
    end
  endtask

  // Plain ticks until the sequence ends; noisy ticks carry random SDA and
  // now and then a stray command that must be rejected.
  task automatic run_out(input logic sda, input bit noisy);
    in_item_t it;
    while (bus_ph != PH_IDLE) begin
      it        = '0;
      it.sda_in = sda;
      if (noisy) begin
        it      = rand_item(FUNC_NONE);
        it.func = ($urandom_range(99) < NOISE_PCT) ? cmd_set[$urandom_range(2)] : FUNC_NONE;
      end
      send_item(it);
    end
  endtask

  // Wait for every result and the pipeline to empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tick_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Finish any sequence, then drain.
  task automatic settle_bus();
    run_out(1'b1, 1'b0);
    drain_results();
  endtask

  task automatic program_ticks(input logic [15:0] v);
    settle_bus();
    phase_ticks_we_i <= 1'b1;
    phase_ticks_i    <= v;
    @(posedge clk_i);
    phase_ticks_we_i <= 1'b0;
    tick_len = v;
  endtask

  // Mostly well-formed transfers: start, one or two bytes (cut short on a
  // nack), stop. The rest are lone commands, including write/stop without start.
  task automatic random_traffic(input int n_cmds);
    int goal;
    int n_bytes;
    goal = cmds_sent + n_cmds;
    while (cmds_sent < goal) begin
      if ($urandom_range(9) < 8) begin
        send_item(rand_item(FUNC_START));
        run_out(1'b1, 1'b1);
        n_bytes = $urandom_range(1, 2);
        for (int k = 0; k < n_bytes && !last_nack; k++) begin
          send_item(rand_item(FUNC_WRITE));
          run_out(1'b1, 1'b1);
        end
        send_item(rand_item(FUNC_STOP));
        run_out(1'b1, 1'b1);
      end else begin
        send_item(rand_item(cmd_set[$urandom_range(2)]));
        run_out(1'b1, 1'b1);
      end
    end
  endtask

  // Receiver: random stalls per pace, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result checker: one prediction per taken result, compared bit by bit
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (tick_q.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing expected", out_item_o));
      end else begin
        want_r = tick_q.pop_front();
        for (int b = 0; b < $bits(out_item_t); b++) begin
          if (out_item_o[b] !== want_r[b])
            report_mismatch($sformatf("result %0d field %s: got %b want %b",
                                      results_seen, field_name[b], out_item_o[b], want_r[b]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, tick_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    //          func        addr   rw    data   lsb   sda   run   known want
    script = '{
      step_row(FUNC_NONE,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, BUS_IDLE),
      step_row(FUNC_STOP,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, STOP_ENTRY),
      step_row(FUNC_START, 7'h7F, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, SEQ_ENTRY),
      step_row(FUNC_WRITE, 7'h00, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, REJECTED_TICK),
      step_row(FUNC_STOP,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0),
      step_row(FUNC_START, 7'h55, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0),
      step_row(FUNC_WRITE, 7'h00, 1'b0, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0, '0),
      step_row(FUNC_WRITE, 7'h00, 1'b0, 8'h5A, 1'b0, 1'b0, 1'b1, 1'b0, '0),
      step_row(FUNC_STOP,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0),
      step_row(FUNC_NONE,  7'h7F, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, BUS_IDLE),
      step_row(FUNC_WRITE, 7'h00, 1'b0, 8'h81, 1'b0, 1'b0, 1'b1, 1'b0, '0),
      step_row(FUNC_STOP,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0)
    };
    set_pace(PACE_FULL);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a stop without start at the reset phase length, then at
    // one tick per phase: commands while busy, address ack, data nack and
    // ack (LSB first and MSB first in turn), write without start.
    foreach (script[n]) begin
      if (n == FAST_ROW) program_ticks(16'd1);
      send_item(script[n].item);
      if (script[n].known) begin
        void'(tick_q.pop_back());
        tick_q.push_back(script[n].want);
      end
      if (script[n].run_out) run_out(script[n].item.sda_in, 1'b0);
    end

    // Zero phase length behaves as one tick
    program_ticks(16'd0);
    set_pace(PACE_SEND_GAPS);
    random_traffic(3);

    // Long receiver hold-off at full input rate, so the core backs up
    program_ticks(16'd1);
    set_pace(PACE_FULL);
    hold_left = LONG_HOLD;
    random_traffic(2);
    set_pace(PACE_RECV_GAPS);
    random_traffic(3);

    program_ticks(16'd2);
    set_pace(PACE_BOTH_GAPS);
    random_traffic(1);

    // Longest phase: a stop stays in its first phase; a write there is rejected
    program_ticks(16'hFFFF);
    set_pace(PACE_FULL);
    send_item(rand_item(FUNC_STOP));
    send_item(rand_item(FUNC_WRITE));
    repeat (PEEK_TICKS) send_item(rand_item(FUNC_NONE));
    drain_results();

    $display("covered %0d ticks, %0d results, %0d commands (%0d rejected), %0d bytes (%0d nack), %0d stops",
             items_sent, results_seen, cmds_sent, rejects_seen, bytes_seen, nacks_seen, stops_seen);
    $display("phase lengths 0, 1, 2, 4 and 65535, four idling patterns, one long receiver hold-off");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/i2cmbw_pkg.sv
hdl/i2cmbw_seq.sv
hdl/i2c_master_byte_writer_core.sv
tb/testbench.sv
